### sv/pta_pkg.sv
// pta_pkg: shared constants, codes and payload types of the pixel tone adjust unit
// no dependencies; every other file of the block imports it
package pta_pkg;

  // fixed-point format of the gain factors: unsigned Q3.FRACTION_BITS
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned KW            = FRACTION_BITS + 3;

  // contrast divider widths: divisor up to 255*387, dividend up to 259*382 << F plus rounding
  localparam int unsigned DW   = 17;
  localparam int unsigned NW   = DW + FRACTION_BITS;
  localparam int unsigned CNTW = $clog2(NW + 1);

  // percent gain without a divider: 2^F = PCT_Q*100 + PCT_R, the remainder part
  // (PCT_R*n + 50) / 100 by reciprocal multiply, exact for every n up to 227
  localparam int unsigned PCT_Q     = (1 << FRACTION_BITS) / 100;
  localparam int unsigned PCT_R     = (1 << FRACTION_BITS) % 100;
  localparam int unsigned PCT_SH    = 20;
  localparam int unsigned PCT_RECIP = ((1 << PCT_SH) + 99) / 100;
  localparam int unsigned PCT_RW    = 15;
  localparam int unsigned PCT_PW    = PCT_RW + 14;

  // datapath widths: product, rounded quotient, signed result before the clamp
  localparam int unsigned PW = KW + 8;
  localparam int unsigned QW = PW - FRACTION_BITS + 1;
  localparam int unsigned SW = QW + 2;

  // apb address width: four 32-bit registers
  localparam int unsigned AW = 4;

  localparam logic [KW-1:0] FACTOR_ONE = KW'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    MODE_BRIGHT   = 2'd0,
    MODE_CONTRAST = 2'd1,
    MODE_SAT      = 2'd2,
    MODE_INVERT   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_BRIGHT   = 2'd1,
    REG_CONTRAST = 2'd2,
    REG_SAT      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FSEL_BRIGHT   = 2'd0,
    FSEL_CONTRAST = 2'd1,
    FSEL_SAT      = 2'd2
  } fsel_e;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_WAIT = 1'b1
  } ctl_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  // live configuration seen by the pixel pipeline
  typedef struct packed {
    mode_e         mode;
    logic [KW-1:0] kb;
    logic [KW-1:0] kc;
    logic [KW-1:0] ks;
  } cfg_t;

  typedef struct packed {
    logic          start;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [KW-1:0] quot;
  } div_rsp_t;

endpackage

### sv/pta_divider.sv
// pta_divider: restoring serial divider, one quotient bit per cycle
// depends on pta_pkg for widths and the request and response structs
module pta_divider
  import pta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            run_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   rem_d;
  logic [NW-1:0]   quo_q;
  logic [NW-1:0]   quo_d;
  logic [DW-1:0]   den_q;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;

  // one trial subtraction
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
    quo_d = {quo_q[NW-2:0], fits};
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(NW);
    end else if (run_q) begin
      cnt_q  <= cnt_q - CNTW'(1);
      run_q  <= (cnt_q != CNTW'(1));
      done_q <= (cnt_q == CNTW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q[KW-1:0];

endmodule

### sv/pta_regs.sv
// pta_regs: apb register file and gain factor refresh control
// depends on pta_pkg; instantiates pta_divider for the contrast factor division
module pta_regs
  import pta_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cfg_t          cfg_o,
  output logic          busy_o
);

  mode_e         mode_q;
  logic [7:0]    bl_q;
  logic [7:0]    cl_q;
  logic [7:0]    sl_q;
  logic [KW-1:0] kb_q;
  logic [KW-1:0] kc_q;
  logic [KW-1:0] ks_q;
  logic [2:0]    pend_q;
  logic [2:0]    pend_d;
  logic [2:0]    pend_set;
  logic [2:0]    pend_clr;
  ctl_e          state_q;
  ctl_e          state_d;
  fsel_e         pick_sel;
  logic          pct_upd;

  logic          wr_en;
  reg_idx_e      wr_idx;

  logic [7:0]          pct_lvl;
  logic signed [8:0]   pct_n;
  logic [7:0]          pct_m;
  logic [PCT_RW-1:0]   pct_rem;
  logic [PCT_PW-1:0]   pct_rdv;
  logic [KW-1:0]       pct_k;
  logic [8:0]          c_off;
  logic [8:0]          c_dif;
  logic [DW-1:0]       c_t;
  logic [DW-1:0]       c_den;
  logic [NW-1:0]       c_num;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[AW-1:2]);

  // read mux
  always_comb begin
    unique case (reg_idx_e'(paddr[AW-1:2]))
      REG_MODE:     prdata = 32'(mode_q);
      REG_BRIGHT:   prdata = 32'(bl_q);
      REG_CONTRAST: prdata = 32'(cl_q);
      REG_SAT:      prdata = 32'(sl_q);
      default:      prdata = '0;
    endcase
  end

  // level writes flag the matching factor for recompute
  always_comb begin
    pend_set = '0;
    if (wr_en) begin
      unique case (wr_idx)
        REG_BRIGHT:   pend_set[FSEL_BRIGHT]   = 1'b1;
        REG_CONTRAST: pend_set[FSEL_CONTRAST] = 1'b1;
        REG_SAT:      pend_set[FSEL_SAT]      = 1'b1;
        default:      pend_set = '0;
      endcase
    end
  end

  // pending factor with lowest index goes first
  always_comb begin
    if (pend_q[FSEL_BRIGHT]) begin
      pick_sel = FSEL_BRIGHT;
    end else if (pend_q[FSEL_CONTRAST]) begin
      pick_sel = FSEL_CONTRAST;
    end else begin
      pick_sel = FSEL_SAT;
    end
  end

  // percent factor: ((100 + level) << F + 50) / 100, zero for non-positive gain
  always_comb begin
    pct_lvl = (pick_sel == FSEL_SAT) ? sl_q : bl_q;
    pct_n   = 9'sd100 + $signed({pct_lvl[7], pct_lvl});
    pct_m   = pct_n[7:0];
    pct_rem = PCT_RW'(PCT_R) * PCT_RW'(pct_m) + PCT_RW'(50);
    pct_rdv = PCT_PW'(pct_rem) * PCT_PW'(PCT_RECIP);
    if (pct_n <= 9'sd0) begin
      pct_k = '0;
    end else begin
      pct_k = KW'(PCT_Q) * KW'(pct_m) + KW'(pct_rdv[PCT_PW-1:PCT_SH]);
    end
  end

  // contrast factor: (259*(c+255) << F + den/2) / (255*(259-c))
  always_comb begin
    c_off = {cl_q[7], cl_q} + 9'd255;
    c_dif = 9'd259 - {cl_q[7], cl_q};
    c_t   = DW'(c_off) * DW'(259);
    c_den = DW'(c_dif) * DW'(255);
    c_num = NW'({c_t, {FRACTION_BITS{1'b0}}}) + NW'(c_den >> 1);
  end

  // percent factors reload straight from the percent formula, contrast goes through the divider
  assign pct_upd = (state_q == CTL_IDLE) && (|pend_q) && (pick_sel != FSEL_CONTRAST);

  // refresh sequencer: next state and divider request
  always_comb begin
    state_d       = state_q;
    pend_clr      = '0;
    div_req.start = 1'b0;
    div_req.num   = c_num;
    div_req.den   = c_den;
    unique case (state_q)
      CTL_IDLE: begin
        if (|pend_q) begin
          pend_clr[pick_sel] = 1'b1;
          if (pick_sel == FSEL_CONTRAST) begin
            div_req.start = 1'b1;
            state_d       = CTL_WAIT;
          end
        end
      end
      CTL_WAIT: begin
        if (div_rsp.done) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
    pend_d = (pend_q & ~pend_clr) | pend_set;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // configuration registers and gain factors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BRIGHT;
      bl_q   <= '0;
      cl_q   <= '0;
      sl_q   <= '0;
      kb_q   <= FACTOR_ONE;
      kc_q   <= FACTOR_ONE;
      ks_q   <= FACTOR_ONE;
    end else begin
      if (wr_en) begin
        unique case (wr_idx)
          REG_MODE:     mode_q <= mode_e'(pwdata[1:0]);
          REG_BRIGHT:   bl_q   <= pwdata[7:0];
          REG_CONTRAST: cl_q   <= pwdata[7:0];
          REG_SAT:      sl_q   <= pwdata[7:0];
          default:      mode_q <= mode_q;
        endcase
      end
      if (pct_upd) begin
        if (pick_sel == FSEL_SAT) begin
          ks_q <= pct_k;
        end else begin
          kb_q <= pct_k;
        end
      end
      if ((state_q == CTL_WAIT) && div_rsp.done) begin
        kc_q <= div_rsp.quot;
      end
    end
  end

  pta_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_o.mode = mode_q;
  assign cfg_o.kb   = kb_q;
  assign cfg_o.kc   = kc_q;
  assign cfg_o.ks   = ks_q;
  assign busy_o     = (state_q != CTL_IDLE) || (|pend_q);

endmodule

### sv/pta_pipe.sv
// pta_pipe: five-stage pixel datapath (capture, gray, offset, multiply, round and clamp)
// depends on pta_pkg for the payload structs, configuration struct and widths
module pta_pipe
  import pta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     hold_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pix_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_data_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic take;

  // stage 1: captured pixel
  logic [2:0][7:0] px1_q;
  logic [7:0]      a1_q;
  // stage 2: pixel and gray
  logic [2:0][7:0] px2_q;
  logic [7:0]      gray2_q;
  logic [7:0]      a2_q;
  // stage 3: magnitude, sign, base, factor
  logic [2:0][7:0] mag3_q;
  logic [2:0]      neg3_q;
  logic [7:0]      base3_q;
  logic [KW-1:0]   k3_q;
  logic [7:0]      a3_q;
  // stage 4: products
  logic [2:0][PW-1:0] prod4_q;
  logic [2:0]         neg4_q;
  logic [7:0]         base4_q;
  logic [7:0]         a4_q;
  // output register
  pix_out_t out_q;

  logic [12:0]            gsum;
  logic [2:0][7:0]        mag_d;
  logic [2:0]             neg_d;
  logic [7:0]             base_d;
  logic [KW-1:0]          k_d;
  logic signed [9:0]      dv;
  logic [9:0]             dabs;
  logic [2:0][PW-1:0]     prod_d;
  logic [PW:0]            rsum;
  logic [QW-1:0]          qm;
  logic signed [SW-1:0]   sv;
  logic [2:0][7:0]        res_d;

  // per-stage ready: a stage moves when it is empty or the next one moves
  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1 && !hold_i;
  assign take       = in_valid_i && in_ready_o;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= take;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // gray = (11r + 16g + 5b) / 32
  always_comb begin
    gsum = 13'(px1_q[0]) * 13'd11 + 13'(px1_q[1]) * 13'd16 + 13'(px1_q[2]) * 13'd5;
  end

  // offset about the pivot of the selected mode; invert is unit gain on -x about 255
  always_comb begin
    unique case (cfg_i.mode)
      MODE_BRIGHT:   begin base_d = 8'd0;    k_d = cfg_i.kb;   end
      MODE_CONTRAST: begin base_d = 8'd128;  k_d = cfg_i.kc;   end
      MODE_SAT:      begin base_d = gray2_q; k_d = cfg_i.ks;   end
      MODE_INVERT:   begin base_d = 8'd255;  k_d = FACTOR_ONE; end
      default:       begin base_d = 8'd0;    k_d = cfg_i.kb;   end
    endcase
    for (int c = 0; c < 3; c++) begin
      unique case (cfg_i.mode)
        MODE_BRIGHT:   dv = $signed({2'b00, px2_q[c]});
        MODE_CONTRAST: dv = $signed({2'b00, px2_q[c]} - 10'd128);
        MODE_SAT:      dv = $signed({2'b00, px2_q[c]} - {2'b00, gray2_q});
        MODE_INVERT:   dv = $signed(10'd0 - {2'b00, px2_q[c]});
        default:       dv = $signed({2'b00, px2_q[c]});
      endcase
      dabs     = dv[9] ? (10'd0 - 10'(dv)) : 10'(dv);
      neg_d[c] = dv[9];
      mag_d[c] = dabs[7:0];
    end
  end

  // gain multiply, one lane per colour
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_d[c] = PW'(k3_q) * PW'(mag3_q[c]);
    end
  end

  // floor of the signed product, add base, clamp to 0..255
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rsum = {1'b0, prod4_q[c]} + (neg4_q[c] ? (PW + 1)'(FACTOR_ONE - KW'(1)) : '0);
      qm   = rsum[PW:FRACTION_BITS];
      if (neg4_q[c]) begin
        sv = $signed(SW'(base4_q) - SW'(qm));
      end else begin
        sv = $signed(SW'(base4_q) + SW'(qm));
      end
      if (sv[SW-1]) begin
        res_d[c] = 8'd0;
      end else if (|sv[SW-2:8]) begin
        res_d[c] = 8'd255;
      end else begin
        res_d[c] = sv[7:0];
      end
    end
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && take) begin
      px1_q <= {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};
      a1_q  <= in_data_i.alpha_in;
    end
    if (rdy2 && v1_q) begin
      px2_q   <= px1_q;
      gray2_q <= gsum[12:5];
      a2_q    <= a1_q;
    end
    if (rdy3 && v2_q) begin
      mag3_q  <= mag_d;
      neg3_q  <= neg_d;
      base3_q <= base_d;
      k3_q    <= k_d;
      a3_q    <= a2_q;
    end
    if (rdy4 && v3_q) begin
      prod4_q <= prod_d;
      neg4_q  <= neg3_q;
      base4_q <= base3_q;
      a4_q    <= a3_q;
    end
    if (rdy5 && v4_q) begin
      out_q.red_out   <= res_d[0];
      out_q.green_out <= res_d[1];
      out_q.blue_out  <= res_d[2];
      out_q.alpha_out <= a4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_data_o  = out_q;

endmodule

### sv/pixel_tone_adjust_unit.sv
// pixel tone adjust unit: a pixel goes through the capture, gray, offset, multiply and output
// registers. throughput is one pixel per clock unless back pressure or a factor refresh holds the
// input; every stage holds its own valid bit, so bubbles fill while a result waits at the output
// register. a brightness or saturation write holds in_ready_o low while that factor reloads;
// a contrast write holds it low while the serial divider makes 33 quotient bits.
// reset clears the pipeline and registers; the gain factors come up at 1.0.
module pixel_tone_adjust_unit
  import pta_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pix_in_t       in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pix_out_t      out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t cfg;
  logic busy;

  // registers and factor refresh
  pta_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .busy_o  (busy)
  );

  // pixel datapath
  pta_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .hold_i      (busy),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/pta_checker.sv
// pta_checker: port-level assertions for the pixel tone adjust unit, bound to the top level
// depends on pta_pkg and pixel_tone_adjust_unit
module pta_checker
  import pta_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input pix_in_t       in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pix_out_t      out_data_o,
  input logic          psel,
  input logic          penable,
  input logic          pwrite,
  input logic [AW-1:0] paddr,
  input logic [31:0]   pwdata,
  input logic [31:0]   prdata,
  input logic          pready
);

  logic lvl_wr;
  assign lvl_wr = psel && penable && pwrite && pready &&
                  (reg_idx_e'(paddr[AW-1:2]) != REG_MODE);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // a level write blocks input while the factor is recomputed
  a_refresh_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_wr |=> !in_ready_o)
    else $error("input taken during factor refresh");

  // a level register reads back what was written
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_wr |=> (!(psel && !pwrite && (paddr == $past(paddr))) ||
                (prdata[7:0] == $past(pwdata[7:0]))))
    else $error("level register readback mismatch");

  // with no back pressure an accepted pixel reaches the output with its alpha
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && in_ready_o, 5) &&
    $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) &&
    $past(rst_ni, 4) && $past(rst_ni, 5) &&
    $past(out_ready_i, 1) && $past(out_ready_i, 2) &&
    $past(out_ready_i, 3) && $past(out_ready_i, 4)
    |-> out_valid_o && (out_data_o.alpha_out == $past(in_data_i.alpha_in, 5)))
    else $error("pixel latency or alpha mismatch");

endmodule

bind pixel_tone_adjust_unit pta_checker u_pta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);
